[design/scfcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scfcd_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [3:0]  IDLE_INDEX = 4'd8;
  localparam logic [3:0]  DATA_LEN   = 4'd4;

  localparam logic [3:0] IDX_HUM_HI  = 4'd2;
  localparam logic [3:0] IDX_HUM_LO  = 4'd3;
  localparam logic [3:0] IDX_TMP_HI  = 4'd4;
  localparam logic [3:0] IDX_TMP_LO  = 4'd5;
  localparam logic [3:0] IDX_CRC_LO  = DATA_LEN + 4'd2;
  localparam logic [3:0] IDX_CRC_HI  = DATA_LEN + 4'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic               crc_ok;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } result_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/scfcd_frame_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module scfcd_frame_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire scfcd_pkg::byte_item_t   item,
  output logic                         emit,
  output scfcd_pkg::result_item_t      result
);
  import scfcd_pkg::*;

  logic [15:0] crc_accum, crc_accum_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [15:0] humidity_word, humidity_word_next;
  logic [15:0] temperature_word, temperature_word_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic [15:0] crc_base;
  logic [3:0]  idx;
  logic        idle;
  logic [15:0] crc_rx;
  logic [15:0] temp_mag;

  always_comb begin
    crc_base = item.frame_start ? CRC_INIT : crc_accum;
    idx      = item.frame_start ? 4'd0 : byte_index;
    idle     = (idx >= IDLE_INDEX);

    crc_accum_next        = crc_base;
    byte_index_next       = IDLE_INDEX;
    humidity_word_next    = humidity_word;
    temperature_word_next = temperature_word;
    crc_low_byte_next     = crc_low_byte;
    emit                  = 1'b0;

    if (!idle) begin
      if (idx < IDX_CRC_LO) begin
        crc_accum_next = crc_byte(crc_base, item.data_byte);
      end
      case (idx)
        IDX_HUM_HI: humidity_word_next    = {item.data_byte, humidity_word[7:0]};
        IDX_HUM_LO: humidity_word_next    = {humidity_word[15:8], item.data_byte};
        IDX_TMP_HI: temperature_word_next = {item.data_byte, temperature_word[7:0]};
        IDX_TMP_LO: temperature_word_next = {temperature_word[15:8], item.data_byte};
        IDX_CRC_LO: crc_low_byte_next     = item.data_byte;
        default: ;
      endcase
      if (idx == IDX_CRC_HI) begin
        emit            = 1'b1;
        byte_index_next = IDLE_INDEX;
      end else begin
        byte_index_next = idx + 4'd1;
      end
    end

    crc_rx   = {item.data_byte, crc_low_byte};
    temp_mag = {1'b0, temperature_word[14:0]};
    result.crc_ok             = (crc_base == crc_rx);
    result.humidity_tenths    = humidity_word;
    result.temperature_tenths = temperature_word[15] ? (16'd0 - temp_mag) : temp_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum        <= CRC_INIT;
      byte_index       <= IDLE_INDEX;
      humidity_word    <= '0;
      temperature_word <= '0;
      crc_low_byte     <= '0;
    end else if (fire) begin
      crc_accum        <= crc_accum_next;
      byte_index       <= byte_index_next;
      humidity_word    <= humidity_word_next;
      temperature_word <= temperature_word_next;
      crc_low_byte     <= crc_low_byte_next;
    end
  end

endmodule

`default_nettype wire

[design/sensor_frame_crc_check_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

// Checks and decodes an 8-byte humidity/temperature sensor reply taken one
// byte per item; frame_start marks byte 0 and restarts any partial frame.
// CRC-16 (reflected 0xA001, init 0xFFFF) over bytes 0..5 is compared with
// the little-endian CRC in bytes 6..7, and one result (crc_ok, humidity,
// two's-complement temperature) is given on byte 7. Bytes outside a frame
// are dropped. One byte per cycle is taken while byte_stall is low; a byte
// passes through an input register and its result appears from the output
// register. The byte update (unrolled CRC step) sits between those registers.
// While a result waits under result_stall, a full input register holds and
// byte_stall rises.
module sensor_frame_crc_check_decode (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     byte_valid,
  output logic                          byte_stall,
  input  wire scfcd_pkg::byte_item_t    byte_item,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output scfcd_pkg::result_item_t       result_item
);
  import scfcd_pkg::*;

  logic         in_full;
  byte_item_t   in_q;
  logic         fire;
  logic         emit;
  result_item_t core_result;

  assign fire       = in_full && (!result_valid || !result_stall);
  assign byte_stall = in_full && !fire;

  scfcd_frame_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .emit   (emit),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_item;
    end
    if (fire && emit) begin
      result_item <= core_result;
    end
  end

endmodule

`default_nettype wire

[bench/sensor_frame_crc_check_decode_tb.sv]
`timescale 1ns / 1ps

module sensor_frame_crc_check_decode_tb;
  import scfcd_pkg::*;

  localparam int RAND_ITEMS  = 650;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 80;
  localparam int DIR_N       = 26;

  // how the CRC bytes of a frame are filled in at drive time
  typedef enum logic [1:0] {FILL_RAW, FILL_CRC_LO, FILL_CRC_HI, FILL_BAD_HI} crc_fill_t;

  typedef struct packed {
    logic [7:0]   b;
    logic         st;
    crc_fill_t    fill;
    logic         typed;
    result_item_t want;
  } row_t;

  localparam row_t DIR_ROWS [DIR_N] = '{
    // idle byte, ignored
    '{8'hA5, 1'b0, FILL_RAW,    1'b0, 33'h0},
    // good CRC, humidity max, negative zero
    '{8'h03, 1'b1, FILL_RAW,    1'b0, 33'h0},
    '{8'h04, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'hFF, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'hFF, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h80, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_CRC_HI, 1'b1, {1'b1, 16'hFFFF, 16'h0000}},
    // CRC mismatch, humidity zero, most negative temperature
    '{8'h03, 1'b1, FILL_RAW,    1'b0, 33'h0},
    '{8'h04, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'hFF, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'hFF, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_BAD_HI, 1'b1, {1'b0, 16'h0000, 16'h8001}},
    // partial frame abandoned by a restart, then most positive temperature
    '{8'h03, 1'b1, FILL_RAW,    1'b0, 33'h0},
    '{8'hFF, 1'b1, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h12, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h34, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h7F, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'hFF, 1'b0, FILL_RAW,    1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, 33'h0},
    '{8'h00, 1'b0, FILL_CRC_HI, 1'b1, {1'b1, 16'h1234, 16'h7FFF}}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_item_t   byte_item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;

  // decoder state
  logic [15:0] crc_reg    = CRC_INIT;
  logic [3:0]  frame_pos  = IDLE_INDEX;
  logic [15:0] hum_reg    = '0;
  logic [15:0] tmp_reg    = '0;
  logic [7:0]  crc_lo_reg = '0;

  result_item_t expected_results [$];
  int  errors        = 0;
  int  bytes_taken   = 0;
  int  bytes_ignored = 0;
  int  results_seen  = 0;
  int  crc_fails     = 0;
  int  cycle_count   = 0;
  int  hold_left     = 0;
  bit  hold_go       = 1'b0;
  bit  hold_done     = 1'b0;
  bit  calm          = 1'b0;

  sensor_frame_crc_check_decode u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [7:0] fill_byte(logic [7:0] b, crc_fill_t fill);
    case (fill)
      FILL_CRC_LO: return crc_reg[7:0];
      FILL_CRC_HI: return crc_reg[15:8];
      FILL_BAD_HI: return crc_reg[15:8] ^ (8'h01 << $urandom_range(7));
      default:     return b;
    endcase
  endfunction

  task automatic decode_byte(input byte_item_t it, output bit taken, output bit made,
                             output result_item_t res);
    logic [3:0]  pos;
    logic [15:0] mag;
    taken = 1'b0;
    made  = 1'b0;
    res   = '0;
    if (it.frame_start) begin
      crc_reg   = CRC_INIT;
      frame_pos = '0;
    end
    pos = frame_pos;
    if (pos >= IDLE_INDEX) begin
      frame_pos = IDLE_INDEX;
      return;
    end
    taken = 1'b1;
    if (pos < IDX_CRC_LO) crc_reg = crc16_step(crc_reg, it.data_byte);
    case (pos)
      IDX_HUM_HI: hum_reg[15:8] = it.data_byte;
      IDX_HUM_LO: hum_reg[7:0]  = it.data_byte;
      IDX_TMP_HI: tmp_reg[15:8] = it.data_byte;
      IDX_TMP_LO: tmp_reg[7:0]  = it.data_byte;
      IDX_CRC_LO: crc_lo_reg    = it.data_byte;
      default: ;
    endcase
    if (pos == IDX_CRC_HI) begin
      // sign-magnitude to two's complement
      mag = {1'b0, tmp_reg[14:0]};
      res.crc_ok             = (crc_reg == {it.data_byte, crc_lo_reg});
      res.humidity_tenths    = hum_reg;
      res.temperature_tenths = tmp_reg[15] ? 16'h0000 - mag : mag;
      made      = 1'b1;
      frame_pos = IDLE_INDEX;
    end else begin
      frame_pos = pos + 4'd1;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [32:0] got,
                                 input logic [32:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycle_count);
    errors++;
  endtask

  task automatic check_result(input result_item_t got);
    result_item_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("result with none pending", got, '0);
      return;
    end
    want = expected_results.pop_front();
    if (!want.crc_ok) crc_fails++;
    if (got.crc_ok !== want.crc_ok)
      report_mismatch("crc_ok", 33'(got.crc_ok), 33'(want.crc_ok));
    if (got.humidity_tenths !== want.humidity_tenths)
      report_mismatch("humidity_tenths", 33'(got.humidity_tenths),
                      33'(want.humidity_tenths));
    if (got.temperature_tenths !== want.temperature_tenths)
      report_mismatch("temperature_tenths", 33'(got.temperature_tenths),
                      33'(want.temperature_tenths));
  endtask

  // result side: check, random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result_item);
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  task automatic push_byte(input byte_item_t it, input bit typed, input result_item_t want);
    bit taken;
    bit made;
    result_item_t res;
    if (!calm) begin
      while ($urandom_range(99) < 37) begin
        byte_valid <= 1'b0;
        @(posedge clk);
      end
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    decode_byte(it, taken, made, res);
    if (typed) expected_results.push_back(want);
    else if (made) expected_results.push_back(res);
    if (taken) bytes_taken++;
    else bytes_ignored++;
  endtask

  task automatic send_frame(input int len, input crc_fill_t hi_fill, input int stray_pct);
    logic [7:0]  fb [8];
    logic [15:0] hum;
    logic [15:0] tmp;
    byte_item_t  it;
    foreach (fb[i]) fb[i] = 8'($urandom_range(255));
    if ($urandom_range(3) != 0) fb[0] = 8'h03;
    if ($urandom_range(3) != 0) fb[1] = 8'h04;
    hum = 16'($urandom_range(16'hFFFF));
    tmp = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(9))
      0: hum = 16'h0000;
      1: hum = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(9))
      0: tmp = 16'h8000;
      1: tmp = 16'hFFFF;
      2: tmp = 16'h7FFF;
      3: tmp = 16'h0000;
      default: ;
    endcase
    {fb[2], fb[3], fb[4], fb[5]} = {hum, tmp};
    for (int i = 0; i < len; i++) begin
      it.frame_start = (i == 0) || ($urandom_range(99) < stray_pct);
      it.data_byte   = fb[i];
      if (i == 6 && hi_fill != FILL_RAW) it.data_byte = fill_byte(fb[i], FILL_CRC_LO);
      if (i == 7) it.data_byte = fill_byte(fb[i], hi_fill);
      push_byte(it, 1'b0, '0);
    end
  endtask

  function automatic crc_fill_t pick_crc_fill();
    int r;
    r = $urandom_range(9);
    if (r < 7) return FILL_CRC_HI;
    if (r < 9) return FILL_BAD_HI;
    return FILL_RAW;
  endfunction

  initial begin
    byte_item_t it;
    int base;
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[r]) begin
      it.frame_start = DIR_ROWS[r].st;
      it.data_byte   = fill_byte(DIR_ROWS[r].b, DIR_ROWS[r].fill);
      push_byte(it, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    base    = bytes_taken;
    hold_go = 1'b1;
    while (bytes_taken - base < RAND_ITEMS) begin
      calm = (bytes_taken - base >= 250) && (bytes_taken - base < 400);
      pick = $urandom_range(99);
      if (pick < 72) begin
        send_frame(8, pick_crc_fill(), 0);
      end else if (pick < 84) begin
        send_frame($urandom_range(1, 7), pick_crc_fill(), 0);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 3)) begin
          it.frame_start = 1'b0;
          it.data_byte   = 8'($urandom_range(255));
          push_byte(it, 1'b0, '0);
        end
      end else begin
        send_frame(8, pick_crc_fill(), 15);
      end
    end
    calm = 1'b0;
    byte_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d frame bytes and %0d idle bytes, %0d results (%0d with bad CRC)",
             bytes_taken, bytes_ignored, results_seen, crc_fails);
    $display("random frames with restarts, truncation, stalls and an %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/scfcd_pkg.sv
design/scfcd_frame_core.sv
design/sensor_frame_crc_check_decode.sv
bench/sensor_frame_crc_check_decode_tb.sv
